@@ sv/udpc_pkg.sv @@
package udpc_pkg;

	localparam int WORD_W = 16;
	localparam int POS_W  = 3;

	// position of the UDP checksum field within the segment
	localparam logic [POS_W-1:0] CSUM_SLOT = 3'd3;
	localparam logic [POS_W-1:0] POS_LIMIT = 3'd4;

	localparam logic [WORD_W-1:0] ODD_TAIL_MASK = 16'hff00;

	// control for one accumulate step
	typedef struct packed {
		logic fire;
		logic first;
		logic last;
		logic high_byte_only;
	} step_ctl_t;

	// end-around fold of a 17-bit sum; result always fits 16 bits
	function automatic logic [WORD_W-1:0] fold17(input logic [WORD_W:0] s);
		logic [WORD_W:0] t;
		t = {1'b0, s[WORD_W-1:0]} + {{WORD_W{1'b0}}, s[WORD_W]};
		return t[WORD_W-1:0];
	endfunction

endpackage

@@ sv/udpc_pseudo_sum.sv @@
module udpc_pseudo_sum (
	input  logic [31:0]                 source_address,
	input  logic [31:0]                 dest_address,
	input  logic [7:0]                  protocol_number,
	input  logic [15:0]                 segment_length,
	output logic [udpc_pkg::WORD_W-1:0] pseudo
);
	import udpc_pkg::*;

	logic [WORD_W+2:0] total;
	logic [WORD_W:0]   fold_a;

	// five 16-bit terms and one 8-bit term; 19 bits cannot overflow
	assign total = {3'b000, source_address[31:16]}
		+ {3'b000, source_address[15:0]}
		+ {3'b000, dest_address[31:16]}
		+ {3'b000, dest_address[15:0]}
		+ {11'd0, protocol_number}
		+ {3'b000, segment_length};

	assign fold_a = {1'b0, total[WORD_W-1:0]} + {{(WORD_W-2){1'b0}}, total[WORD_W+2:WORD_W]};
	assign pseudo = fold17(fold_a);

endmodule

@@ sv/udpc_accum.sv @@
module udpc_accum (
	input  logic                        clk,
	input  logic                        arst_n,
	input  udpc_pkg::step_ctl_t         step,
	input  logic [udpc_pkg::WORD_W-1:0] word,
	input  logic [udpc_pkg::WORD_W-1:0] pseudo,
	output logic [udpc_pkg::WORD_W-1:0] sum_next
);
	import udpc_pkg::*;

	logic [WORD_W-1:0] sum_q;
	logic [POS_W-1:0]  pos_q;
	logic [WORD_W-1:0] base;
	logic [POS_W-1:0]  pos;
	logic [WORD_W-1:0] term;

	always_comb begin
		base = step.first ? pseudo : sum_q;
		pos  = step.first ? '0 : pos_q;
		term = step.high_byte_only ? (word & ODD_TAIL_MASK) : word;
		if (pos == CSUM_SLOT) begin
			term = '0;
		end
		sum_next = fold17({1'b0, base} + {1'b0, term});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			pos_q <= '0;
		end else if (step.fire) begin
			if (step.last) begin
				sum_q <= '0;
				pos_q <= '0;
			end else begin
				sum_q <= sum_next;
				pos_q <= (pos < POS_LIMIT) ? pos + 1'b1 : pos;
			end
		end
	end

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_LIMIT)
		else $error("word position out of range");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(step.fire && step.last) |=> (sum_q == '0 && pos_q == '0))
		else $error("sum not cleared after last beat");

endmodule

@@ sv/udp_ipv4_checksum.sv @@
// channel   handshake                 payload
// segment   seg_valid / seg_ready     segment_word, high_byte_only, first_word,
//                                     last_word, source_address, dest_address,
//                                     protocol_number, segment_length
// checksum  csum_valid / csum_ready   checksum
//
// One beat per cycle sustained while no last beat waits on a held result. A beat is
// registered (pseudo header already summed) and accumulated from that register, and a
// last beat loads the result register, from which the checksum is presented.
// Reset clears the running sum, word position and both valid flags.
// A held result stalls a last beat in the input register, and the input stalls behind it.
module udp_ipv4_checksum (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        seg_valid,
	output logic        seg_ready,
	input  logic [15:0] segment_word,
	input  logic        high_byte_only,
	input  logic        first_word,
	input  logic        last_word,
	input  logic [31:0] source_address,
	input  logic [31:0] dest_address,
	input  logic [7:0]  protocol_number,
	input  logic [15:0] segment_length,
	output logic        csum_valid,
	input  logic        csum_ready,
	output logic [15:0] checksum
);
	import udpc_pkg::*;

	logic              valid_s1;
	logic [WORD_W-1:0] word_s1;
	logic [WORD_W-1:0] pseudo_s1;
	logic              odd_s1;
	logic              first_s1;
	logic              last_s1;
	logic [WORD_W-1:0] pseudo;
	logic [WORD_W-1:0] sum_next;
	logic              advance;
	logic              out_free;
	logic              seg_fire;
	logic              out_valid_q;
	logic [WORD_W-1:0] checksum_q;
	step_ctl_t         step;

	udpc_pseudo_sum u_pseudo (
		.source_address (source_address),
		.dest_address   (dest_address),
		.protocol_number(protocol_number),
		.segment_length (segment_length),
		.pseudo         (pseudo)
	);

	assign out_free  = !out_valid_q || csum_ready;
	assign advance   = valid_s1 && (!last_s1 || out_free);
	assign seg_ready = !valid_s1 || advance;
	assign seg_fire  = seg_valid && seg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (seg_ready) begin
			valid_s1 <= seg_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (seg_fire) begin
			word_s1   <= segment_word;
			pseudo_s1 <= pseudo;
			odd_s1    <= high_byte_only;
			first_s1  <= first_word;
			last_s1   <= last_word;
		end
	end

	assign step = '{fire: advance, first: first_s1, last: last_s1, high_byte_only: odd_s1};

	udpc_accum u_accum (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.word    (word_s1),
		.pseudo  (pseudo_s1),
		.sum_next(sum_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (csum_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			checksum_q <= ~sum_next;
		end
	end

	assign csum_valid = out_valid_q;
	assign checksum   = checksum_q;

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!seg_ready |-> (valid_s1 && last_s1 && out_valid_q && !csum_ready))
		else $error("input stalled without a blocked last beat");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		(csum_valid && !$past(csum_valid && !csum_ready)) |-> $past(advance && last_s1))
		else $error("result appeared without a last beat");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1) |-> out_free)
		else $error("pending result overwritten");

endmodule

@@ tb/sv/tb.sv @@
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import udpc_pkg::*;

	typedef struct packed {
		logic [15:0] word;
		logic        odd_tail;
		logic        first_mark;
		logic        last_mark;
		logic [31:0] src;
		logic [31:0] dst;
		logic [7:0]  proto;
		logic [15:0] len;
		logic        has_sum;
		logic [15:0] known_sum;
	} seg_beat_t;

	localparam int DIRECTED_ROWS = 25;
	localparam int RANDOM_BEATS  = 600;

	// word, odd, first, last, src, dst, proto, len, has_sum, known_sum
	localparam seg_beat_t DIRECTED [DIRECTED_ROWS] = '{
		// lone last beat right after reset: sum is zero
		'{16'h0000, 1'b0, 1'b0, 1'b1, '0, '0, '0, '0, 1'b1, 16'hffff},
		// all-ones word, empty header: zero result is not turned into ffff
		'{16'hffff, 1'b0, 1'b1, 1'b1, '0, '0, '0, '0, 1'b1, 16'h0000},
		// header fields all ones
		'{16'h0000, 1'b0, 1'b1, 1'b1, '1, '1, 8'hff, 16'hffff, 1'b0, '0},
		// odd tail masks the low byte
		'{16'hffff, 1'b1, 1'b1, 1'b1, '0, '0, '0, '0, 1'b1, 16'h00ff},
		// no first mark: header fields are ignored
		'{16'h1234, 1'b0, 1'b0, 1'b0, 32'hdeadbeef, 32'h01020304, 8'h11, 16'h0010,
			1'b0, '0},
		'{16'h0001, 1'b0, 1'b0, 1'b1, '0, '0, '0, '0, 1'b0, '0},
		// ordinary segment, fourth word is the checksum field
		'{16'h0035, 1'b0, 1'b1, 1'b0, 32'hc0a80001, 32'hc0a800c7, 8'h11, 16'h0009,
			1'b0, '0},
		'{16'h0035, 1'b0, 1'b0, 1'b0, '0, '0, '0, '0, 1'b0, '0},
		'{16'h0009, 1'b0, 1'b0, 1'b0, '0, '0, '0, '0, 1'b0, '0},
		'{16'hbeef, 1'b0, 1'b0, 1'b0, '0, '0, '0, '0, 1'b0, '0},
		'{16'h61ff, 1'b1, 1'b0, 1'b1, '0, '0, '0, '0, 1'b0, '0},
		// long segment: position saturates, only the fourth word is dropped
		'{16'hffff, 1'b0, 1'b1, 1'b0, 32'h0a000001, 32'h0a000002, 8'h11, 16'h0010,
			1'b0, '0},
		'{16'hffff, 1'b0, 1'b0, 1'b0, '0, '0, '0, '0, 1'b0, '0},
		'{16'hffff, 1'b0, 1'b0, 1'b0, '0, '0, '0, '0, 1'b0, '0},
		'{16'hffff, 1'b0, 1'b0, 1'b0, '0, '0, '0, '0, 1'b0, '0},
		'{16'hffff, 1'b0, 1'b0, 1'b0, '0, '0, '0, '0, 1'b0, '0},
		'{16'hffff, 1'b0, 1'b0, 1'b0, '0, '0, '0, '0, 1'b0, '0},
		'{16'hffff, 1'b0, 1'b0, 1'b0, '0, '0, '0, '0, 1'b0, '0},
		'{16'h8000, 1'b0, 1'b0, 1'b1, '0, '0, '0, '0, 1'b0, '0},
		// restart in mid-segment, odd tail on a beat that is not last
		'{16'haaaa, 1'b0, 1'b1, 1'b0, 32'h11111111, 32'h22222222, 8'h06, 16'h0020,
			1'b0, '0},
		'{16'h5555, 1'b0, 1'b0, 1'b0, '0, '0, '0, '0, 1'b0, '0},
		'{16'h0102, 1'b0, 1'b1, 1'b0, 32'h7f000001, 32'h7f000001, 8'h11, 16'h0008,
			1'b0, '0},
		'{16'h12ff, 1'b1, 1'b0, 1'b0, '0, '0, '0, '0, 1'b0, '0},
		'{16'h0001, 1'b0, 1'b0, 1'b1, '0, '0, '0, '0, 1'b0, '0},
		// everything at its maximum
		'{16'hffff, 1'b1, 1'b1, 1'b1, '1, '1, 8'hff, 16'hffff, 1'b0, '0}
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        seg_valid;
	logic        seg_ready;
	logic [15:0] segment_word;
	logic        high_byte_only;
	logic        first_word;
	logic        last_word;
	logic [31:0] source_address;
	logic [31:0] dest_address;
	logic [7:0]  protocol_number;
	logic [15:0] segment_length;
	logic        csum_valid;
	logic        csum_ready;
	logic [15:0] checksum;

	logic [15:0] pending_checksums [$];
	logic [15:0] sum_acc;
	logic [2:0]  word_pos;
	logic [15:0] want_sum;
	logic [31:0] rx_cycle;
	int          burst_left;
	int          beats_sent;
	int          segments_sent;
	int          checked;
	int          errors;

	udp_ipv4_checksum dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.seg_valid       (seg_valid),
		.seg_ready       (seg_ready),
		.segment_word    (segment_word),
		.high_byte_only  (high_byte_only),
		.first_word      (first_word),
		.last_word       (last_word),
		.source_address  (source_address),
		.dest_address    (dest_address),
		.protocol_number (protocol_number),
		.segment_length  (segment_length),
		.csum_valid      (csum_valid),
		.csum_ready      (csum_ready),
		.checksum        (checksum)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] v);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, v};
		return s[15:0] + {15'd0, s[16]};
	endfunction

	// advance the checksum predictor by one accepted beat
	task automatic csum_predict(input seg_beat_t b, output logic produced,
			output logic [15:0] result);
		logic [15:0] w;
		if (b.first_mark) begin
			sum_acc = '0;
			sum_acc = ones_add(sum_acc, b.src[31:16]);
			sum_acc = ones_add(sum_acc, b.src[15:0]);
			sum_acc = ones_add(sum_acc, b.dst[31:16]);
			sum_acc = ones_add(sum_acc, b.dst[15:0]);
			sum_acc = ones_add(sum_acc, {8'd0, b.proto});
			sum_acc = ones_add(sum_acc, b.len);
			word_pos = '0;
		end
		w = b.word;
		if (b.odd_tail)
			w = w & ODD_TAIL_MASK;
		if (word_pos == CSUM_SLOT)
			w = '0;
		sum_acc = ones_add(sum_acc, w);
		if (word_pos < POS_LIMIT)
			word_pos = word_pos + 3'd1;
		produced = b.last_mark;
		result = ~sum_acc;
		if (b.last_mark) begin
			sum_acc = '0;
			word_pos = '0;
		end
	endtask

	task automatic report_error(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		errors++;
	endtask

	// hold the beat until taken, then maybe open a gap
	task automatic send_beat(input seg_beat_t b);
		logic        produced;
		logic [15:0] predicted;
		seg_valid       <= 1'b1;
		segment_word    <= b.word;
		high_byte_only  <= b.odd_tail;
		first_word      <= b.first_mark;
		last_word       <= b.last_mark;
		source_address  <= b.src;
		dest_address    <= b.dst;
		protocol_number <= b.proto;
		segment_length  <= b.len;
		@(posedge clk);
		while (!seg_ready)
			@(posedge clk);
		beats_sent++;
		csum_predict(b, produced, predicted);
		if (produced) begin
			segments_sent++;
			pending_checksums.push_back(b.has_sum ? b.known_sum : predicted);
		end
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			seg_valid <= 1'b0;
			repeat ($urandom_range(1, 8))
				@(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
				: $urandom_range(0, 12);
		end
	endtask

	task automatic drain();
		seg_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_checksums.size() != 0);
	endtask

	function automatic seg_beat_t random_beat();
		seg_beat_t b;
		b.word       = 16'($urandom);
		b.odd_tail   = 1'($urandom_range(0, 1));
		b.first_mark = 1'($urandom_range(0, 1));
		b.last_mark  = 1'($urandom_range(0, 1));
		b.src        = $urandom;
		b.dst        = $urandom;
		b.proto      = 8'($urandom);
		b.len        = 16'($urandom);
		b.has_sum    = 1'b0;
		b.known_sum  = '0;
		return b;
	endfunction

	task automatic send_segment();
		seg_beat_t   b;
		int          n;
		logic        odd_end;
		logic [31:0] src;
		logic [31:0] dst;
		logic [7:0]  proto;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
		odd_end = 1'($urandom_range(0, 1));
		src = $urandom;
		dst = $urandom;
		proto = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h11;
		for (int k = 0; k < n; k++) begin
			b = random_beat();
			b.first_mark = (k == 0);
			b.last_mark = (k == n - 1);
			b.odd_tail = b.last_mark ? odd_end : ($urandom_range(0, 19) == 0);
			if (k == 0) begin
				b.src = src;
				b.dst = dst;
				b.proto = proto;
				if ($urandom_range(0, 3) != 0)
					b.len = 16'(2 * n) - 16'(odd_end);
			end
			send_beat(b);
		end
	endtask

	// checksum side: stall pattern steps through four modes selected by rx_cycle[8:7]
	always @(posedge clk) begin
		if (csum_valid && csum_ready) begin
			if (pending_checksums.size() == 0) begin
				report_error($sformatf("checksum %h with none expected", checksum));
			end else begin
				want_sum = pending_checksums.pop_front();
				checked++;
				if (checksum !== want_sum)
					report_error($sformatf("checksum %h, expected %h", checksum, want_sum));
			end
		end
		rx_cycle = rx_cycle + 1;
		case (rx_cycle[8:7])
			2'd0: csum_ready <= 1'b1;
			2'd1: csum_ready <= (rx_cycle % 3 == 0);
			2'd2: csum_ready <= 1'($urandom_range(0, 1));
			default: csum_ready <= (rx_cycle[4:0] >= 5'd24);
		endcase
	end

	initial begin
		arst_n = 1'b0;
		seg_valid = 1'b0;
		segment_word = '0;
		high_byte_only = 1'b0;
		first_word = 1'b0;
		last_word = 1'b0;
		source_address = '0;
		dest_address = '0;
		protocol_number = '0;
		segment_length = '0;
		csum_ready = 1'b0;
		rx_cycle = '0;
		sum_acc = '0;
		word_pos = '0;
		burst_left = 20;
		beats_sent = 0;
		segments_sent = 0;
		checked = 0;
		errors = 0;
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		repeat (2)
			@(posedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++)
			send_beat(DIRECTED[i]);
		drain();

		while (beats_sent < DIRECTED_ROWS + RANDOM_BEATS) begin
			if ($urandom_range(0, 99) < 85) begin
				send_segment();
			end else begin
				repeat ($urandom_range(1, 6))
					send_beat(random_beat());
			end
			if ($urandom_range(0, 29) == 0)
				drain();
		end
		drain();
		repeat (8)
			@(posedge clk);

		$display("covered %0d beats (%0d directed) over short, long, odd and broken segments",
			beats_sent, DIRECTED_ROWS);
		$display("%0d of %0d checksums compared under sender gaps and receiver stalls",
			checked, segments_sent);
		if (errors == 0)
			$display("PASS udp_ipv4_checksum");
		else
			$display("FAIL udp_ipv4_checksum");
		$finish;
	end

	initial begin
		#5ms;
		$display("timeout with %0d checksums outstanding", pending_checksums.size());
		$display("FAIL udp_ipv4_checksum");
		$finish;
	end

endmodule

@@ udp_ipv4_checksum.f @@
sv/udpc_pkg.sv
sv/udpc_pseudo_sum.sv
sv/udpc_accum.sv
sv/udp_ipv4_checksum.sv
tb/sv/tb.sv
